>>> design/pcpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared types, sizes and helpers of the partition distance block.
// ----------------------------------------------------------------------------
package pcpd_pkg;

  localparam int MAX_COLORS = 64;
  localparam int COLOR_W    = 7;
  localparam int IDX_W      = 6;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = MAX_COLORS * MAX_COLORS;
  localparam int CNT_W      = 17;
  localparam int SUM_W      = 23;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SUM_W-1:0]   sum_t;

  localparam cnt_t   MAX_NODES   = cnt_t'(65536);
  localparam color_t K_RESET     = color_t'(8);
  localparam color_t K_MAX       = color_t'(MAX_COLORS);
  localparam idx_t   IDX_LAST    = idx_t'(MAX_COLORS - 1);
  localparam addr_t  ADDR_LAST   = addr_t'(DEPTH - 1);

  typedef struct packed {
    logic  valid;
    addr_t addr;
    cnt_t  data;
  } write_t;

  typedef struct packed {
    logic  valid;
    addr_t addr;
  } sweep_beat_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v >= MAX_NODES) ? MAX_NODES : cnt_t'(v + 1'b1);
  endfunction

endpackage
`default_nettype wire

>>> design/pcpd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpd_ram
// Pair count memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module pcpd_ram (
  input  wire logic            clk,
  input  wire pcpd_pkg::addr_t rd_addr,
  output pcpd_pkg::cnt_t       rd_data,
  input  wire pcpd_pkg::write_t wr
);

  pcpd_pkg::cnt_t mem [0:pcpd_pkg::DEPTH-1];
  pcpd_pkg::cnt_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> design/pcpd_rmw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpd_rmw
// Read-modify-write of one pair count per beat, forwarding the previous
// write when back-to-back beats hit the same entry.
// ----------------------------------------------------------------------------
module pcpd_rmw (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_valid,
  input  wire pcpd_pkg::addr_t req_addr,
  input  wire pcpd_pkg::cnt_t  rd_data,
  output pcpd_pkg::write_t     wr
);

  logic            s1_valid_r;
  pcpd_pkg::addr_t s1_addr_r;
  logic            fwd_valid_r;
  pcpd_pkg::addr_t fwd_addr_r;
  pcpd_pkg::cnt_t  fwd_data_r;
  pcpd_pkg::cnt_t  cur;
  pcpd_pkg::cnt_t  upd;

  always_comb begin
    cur = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;
    upd = pcpd_pkg::sat_inc(cur);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= req_valid;
      fwd_valid_r <= s1_valid_r;
    end
    s1_addr_r  <= req_addr;
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= upd;
  end

  assign wr.valid = s1_valid_r;
  assign wr.addr  = s1_addr_r;
  assign wr.data  = upd;

endmodule
`default_nettype wire

>>> design/pcpd_rowmax.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpd_rowmax
// Takes the sweep of the pair count memory one entry a cycle, keeps the
// largest count of the current row and adds it to the sum at each row end.
// ----------------------------------------------------------------------------
module pcpd_rowmax (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pcpd_pkg::sweep_beat_t beat,
  input  wire pcpd_pkg::color_t     k_act,
  input  wire pcpd_pkg::cnt_t       rd_data,
  input  wire logic                 clr,
  output pcpd_pkg::sum_t            sum
);

  logic            b_valid_r;
  pcpd_pkg::addr_t b_addr_r;
  pcpd_pkg::cnt_t  best_r;
  pcpd_pkg::cnt_t  best_nxt;
  pcpd_pkg::sum_t  sum_r;
  pcpd_pkg::sum_t  sum_nxt;
  pcpd_pkg::idx_t  row;
  pcpd_pkg::idx_t  col;
  logic            in_range;
  pcpd_pkg::cnt_t  c;
  pcpd_pkg::cnt_t  m;

  always_comb begin
    row      = b_addr_r[pcpd_pkg::ADDR_W-1:pcpd_pkg::IDX_W];
    col      = b_addr_r[pcpd_pkg::IDX_W-1:0];
    in_range = ({1'b0, row} < k_act) && ({1'b0, col} < k_act);
    c        = in_range ? rd_data : '0;
    m        = (c > best_r) ? c : best_r;
    best_nxt = best_r;
    sum_nxt  = sum_r;
    if (clr) begin
      best_nxt = '0;
      sum_nxt  = '0;
    end else if (b_valid_r) begin
      if (col == pcpd_pkg::IDX_LAST) begin
        best_nxt = '0;
        sum_nxt  = pcpd_pkg::sum_t'(sum_r + m);
      end else begin
        best_nxt = m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      best_r    <= '0;
      sum_r     <= '0;
    end else begin
      b_valid_r <= beat.valid;
      best_r    <= best_nxt;
      sum_r     <= sum_nxt;
    end
    b_addr_r <= beat.addr;
  end

  assign sum = sum_r;

endmodule
`default_nettype wire

>>> design/partial_coloring_partition_distance_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// partial_coloring_partition_distance_top
// Approximate partition distance between two partial colourings.
//
// Each beat on the input channel (start high while busy is low) carries one
// node with its colour in both colourings. Nodes are taken one a cycle while
// busy is low; each coloured one bumps a pair count in a 4096-entry memory
// through a read-modify-write with forwarding. The beat marked in_last_node
// closes the set: busy then stays high while the whole memory is swept, one
// entry a cycle, to add up the row maxima and clear the table. The result
// beat is then shown on out_valid for one cycle. The receiver cannot stall.
// cfg_we writes the colour count; the user must write it only while the block
// idles, the block does not enforce this. After reset the memory is cleared
// in a pass over all 4096 entries with busy high; the colour count returns to eight.
// ----------------------------------------------------------------------------
module partial_coloring_partition_distance_top (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire pcpd_pkg::color_t       in_color_first,
  input  wire pcpd_pkg::color_t       in_color_second,
  input  wire logic                   in_last_node,
  input  wire logic                   cfg_we,
  input  wire pcpd_pkg::color_t       cfg_wdata,
  output logic                        out_valid,
  output pcpd_pkg::cnt_t              out_distance,
  output pcpd_pkg::cnt_t              out_uncolored_count,
  output pcpd_pkg::cnt_t              out_node_total
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_RUN    = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_SWEEP  = 6'b001000,
    ST_FLUSH  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t                 state_r;
  state_t                 state_nxt;
  pcpd_pkg::color_t       num_colors_r;
  pcpd_pkg::color_t       k_act;
  pcpd_pkg::addr_t        sw_addr_r;
  pcpd_pkg::addr_t        sw_addr_nxt;
  pcpd_pkg::cnt_t         node_r;
  pcpd_pkg::cnt_t         node_nxt;
  pcpd_pkg::cnt_t         unc_r;
  pcpd_pkg::cnt_t         unc_nxt;
  logic                   out_valid_r;
  pcpd_pkg::cnt_t         out_distance_r;
  pcpd_pkg::cnt_t         out_unc_r;
  pcpd_pkg::cnt_t         out_node_r;
  logic                   accept;
  logic                   coloured;
  pcpd_pkg::addr_t        pair_addr;
  pcpd_pkg::addr_t        rd_addr;
  pcpd_pkg::cnt_t         rd_data;
  pcpd_pkg::write_t       rmw_wr;
  pcpd_pkg::write_t       clr_wr;
  pcpd_pkg::write_t       ram_wr;
  pcpd_pkg::sweep_beat_t  beat;
  pcpd_pkg::sum_t         row_sum;
  pcpd_pkg::sum_t         taken;
  pcpd_pkg::sum_t         node_ext;
  pcpd_pkg::cnt_t         dist_clamp;
  logic                   finish;

  always_comb begin
    k_act     = (num_colors_r > pcpd_pkg::K_MAX) ? pcpd_pkg::K_MAX : num_colors_r;
    busy      = (state_r != ST_RUN);
    accept    = start && !busy;
    coloured  = (in_color_first < k_act) && (in_color_second < k_act);
    pair_addr = {in_color_first[pcpd_pkg::IDX_W-1:0], in_color_second[pcpd_pkg::IDX_W-1:0]};
    rd_addr   = (state_r == ST_SWEEP) ? sw_addr_r : pair_addr;
    finish    = (state_r == ST_FINISH);

    clr_wr.valid = (state_r == ST_CLEAR) || (state_r == ST_SWEEP);
    clr_wr.addr  = sw_addr_r;
    clr_wr.data  = '0;
    ram_wr       = rmw_wr.valid ? rmw_wr : clr_wr;

    beat.valid = (state_r == ST_SWEEP);
    beat.addr  = sw_addr_r;

    taken      = pcpd_pkg::sum_t'(pcpd_pkg::sum_t'(unc_r) + row_sum);
    node_ext   = pcpd_pkg::sum_t'(node_r);
    dist_clamp = (node_ext > taken) ? pcpd_pkg::cnt_t'(node_ext - taken) : '0;
  end

  always_comb begin
    state_nxt   = state_r;
    sw_addr_nxt = sw_addr_r;
    node_nxt    = node_r;
    unc_nxt     = unc_r;
    if (accept) begin
      node_nxt = pcpd_pkg::sat_inc(node_r);
      if (!coloured) begin
        unc_nxt = pcpd_pkg::sat_inc(unc_r);
      end
    end
    unique case (state_r)
      ST_CLEAR: begin
        sw_addr_nxt = pcpd_pkg::addr_t'(sw_addr_r + 1'b1);
        if (sw_addr_r == pcpd_pkg::ADDR_LAST) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept && in_last_node) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        sw_addr_nxt = pcpd_pkg::addr_t'(sw_addr_r + 1'b1);
        if (sw_addr_r == pcpd_pkg::ADDR_LAST) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        node_nxt  = '0;
        unc_nxt   = '0;
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      sw_addr_r    <= '0;
      node_r       <= '0;
      unc_r        <= '0;
      num_colors_r <= pcpd_pkg::K_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_addr_r   <= sw_addr_nxt;
      node_r      <= node_nxt;
      unc_r       <= unc_nxt;
      out_valid_r <= finish;
      if (cfg_we) begin
        num_colors_r <= cfg_wdata;
      end
    end
    if (finish) begin
      out_distance_r <= dist_clamp;
      out_unc_r      <= unc_r;
      out_node_r     <= node_r;
    end
  end

  pcpd_ram u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (ram_wr)
  );

  pcpd_rmw u_rmw (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (accept && coloured),
    .req_addr  (pair_addr),
    .rd_data   (rd_data),
    .wr        (rmw_wr)
  );

  pcpd_rowmax u_rowmax (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .k_act   (k_act),
    .rd_data (rd_data),
    .clr     (finish),
    .sum     (row_sum)
  );

  assign out_valid           = out_valid_r;
  assign out_distance        = out_distance_r;
  assign out_uncolored_count = out_unc_r;
  assign out_node_total      = out_node_r;

endmodule
`default_nettype wire
